@@ hw/rtl/hslc_pkg.sv @@
// Shared constants, types and helper functions for the HSL colorize pixel pipeline.
`timescale 1ns / 1ps

package hslc_pkg;

    // Q16 fixed point reference points
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [18:0] SIX_Q16  = 19'd393216;
    localparam logic [18:0] TWO_Q16  = 19'd131072;

    // Rec.709 luminance weights scaled so that the sum over 255 is Q16
    localparam logic [15:0] COEF_RED   = 16'd13933;
    localparam logic [15:0] COEF_GREEN = 16'd46871;
    localparam logic [15:0] COEF_BLUE  = 16'd4732;

    // floor(2^23 / 255), slightly low: the estimate is short by at most one
    localparam logic [15:0] RECIP_255 = 16'd32896;
    localparam int unsigned RECIP_SHIFT = 23;

    // Register indexes on the configuration port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HUE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT = 2'd2;
    localparam int unsigned CFG_DATA_W = 17;

    // Pipeline depth in register stages
    localparam int unsigned NSTG = 11;

    typedef logic [16:0] t_q16;

    // Saturate a written register value to 1.0
    function automatic t_q16 clamp_reg(input logic [CFG_DATA_W-1:0] v);
        t_q16 r;
        r = (v > ONE_Q16) ? ONE_Q16 : t_q16'(v);
        return r;
    endfunction

    // Hue ramp as a weight on (m2 - m1): zero on the m1 plateau, one on the m2 plateau
    function automatic t_q16 ramp_weight(input logic [18:0] t);
        t_q16        w;
        logic [18:0] down;
        down = 19'd262144 - t;
        if (t < 19'd65536) begin
            w = t[16:0];
        end else if (t < 19'd196608) begin
            w = ONE_Q16;
        end else if (t < 19'd262144) begin
            w = down[16:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

endpackage

@@ hw/rtl/hsl_colorize_pixel.sv @@
// Top level of the HSL colorize pixel filter: an eleven-stage pixel pipeline.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tdata: red, green, blue, alpha (8 bits each)
// m_*       out  m_tvalid / m_tready  m_tdata: red, green, blue, alpha (8 bits each)
// i_cfg_*   in   i_cfg_we             i_cfg_addr: register index, i_cfg_data: 17-bit value
//
// One pixel enters per clock while s_tready is high; each pixel passes through the registered
// stages 0 to 10 in order, and m_tvalid is the valid bit of stage 10.
// Each stage holds at most one multiply or a short add/compare per channel; the depth is set
// by the divide-by-255 reciprocal step, the lightness scale, the m2 product and the ramp.
// Synchronous active-low reset clears the valid bits and sets the three configuration
// registers to one half.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds its transaction without loss or repeat.

module hsl_colorize_pixel (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input pixels
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // in_red, in_green, in_blue, in_alpha
    // output pixels
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // out_red, out_green, out_blue, out_alpha
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [hslc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [hslc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned NSTG = hslc_pkg::NSTG;

    // ------------------------------------------------------------------
    // Configuration registers and values derived from them
    // ------------------------------------------------------------------
    hslc_pkg::t_q16 r_hue, r_sat, r_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue   <= hslc_pkg::HALF_Q16;
            r_sat   <= hslc_pkg::HALF_Q16;
            r_light <= hslc_pkg::HALF_Q16;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hslc_pkg::CFG_HUE:   r_hue   <= hslc_pkg::clamp_reg(i_cfg_data);
                hslc_pkg::CFG_SAT:   r_sat   <= hslc_pkg::clamp_reg(i_cfg_data);
                hslc_pkg::CFG_LIGHT: r_light <= hslc_pkg::clamp_reg(i_cfg_data);
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // Lightness: factor and offset applied to the luminance.
    // Brighten: lum*(1-d) + d; darken: lum*(1+d); d = lightness - half.
    hslc_pkg::t_q16 r_lf, r_loff, n_lf, n_loff;
    // Per-channel ramp weights from the hue
    hslc_pkg::t_q16 r_w_red, r_w_grn, r_w_blu, n_w_red, n_w_grn, n_w_blu;
    logic [18:0] w_h6, w_t_red, w_t_blu;
    logic [19:0] w_t_red_raw;

    always_comb begin
        if (r_light > hslc_pkg::HALF_Q16) begin
            n_lf   = 17'(18'd98304 - {1'b0, r_light});
            n_loff = r_light - hslc_pkg::HALF_Q16;
        end else begin
            n_lf   = r_light + hslc_pkg::HALF_Q16;
            n_loff = '0;
        end

        // hue * 6 with the wrap at six for the red and blue positions
        w_h6        = ({2'b00, r_hue} << 2) + ({2'b00, r_hue} << 1);
        w_t_red_raw = {1'b0, w_h6} + {1'b0, hslc_pkg::TWO_Q16};
        if (w_t_red_raw > {1'b0, hslc_pkg::SIX_Q16}) begin
            w_t_red = 19'(w_t_red_raw - {1'b0, hslc_pkg::SIX_Q16});
        end else begin
            w_t_red = w_t_red_raw[18:0];
        end
        if (w_h6 < hslc_pkg::TWO_Q16) begin
            w_t_blu = w_h6 + (hslc_pkg::SIX_Q16 - hslc_pkg::TWO_Q16);
        end else begin
            w_t_blu = w_h6 - hslc_pkg::TWO_Q16;
        end
        n_w_red = hslc_pkg::ramp_weight(w_t_red);
        n_w_grn = hslc_pkg::ramp_weight(w_h6);
        n_w_blu = hslc_pkg::ramp_weight(w_t_blu);
    end

    // Refreshed every cycle; the user must change the registers only while the pipeline is empty (not enforced here)
    always_ff @(posedge i_clk) begin
        r_lf    <= n_lf;
        r_loff  <= n_loff;
        r_w_red <= n_w_red;
        r_w_grn <= n_w_grn;
        r_w_blu <= n_w_blu;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when its successor advances
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld, n_vld, w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = s_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_tready = w_adv[0];
    assign m_tvalid = r_vld[NSTG-1];

    // Alpha rides along every stage
    logic [7:0] r_alpha [NSTG];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_alpha[0] <= s_tdata[31:24];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_adv[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: weighted channel products
    // ------------------------------------------------------------------
    logic [23:0] r0_pr, r0_pg, r0_pb;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_pr <= {8'd0, hslc_pkg::COEF_RED}   * {16'd0, s_tdata[7:0]};
            r0_pg <= {8'd0, hslc_pkg::COEF_GREEN} * {16'd0, s_tdata[15:8]};
            r0_pb <= {8'd0, hslc_pkg::COEF_BLUE}  * {16'd0, s_tdata[23:16]};
        end
    end

    // Stage 1: luminance sum (at most 255 * 65536, fits 24 bits)
    logic [23:0] r1_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_sum <= r0_pr + r0_pg + r0_pb;
        end
    end

    // Stage 2: quotient estimate by reciprocal multiply
    logic [23:0]    r2_sum;
    hslc_pkg::t_q16 r2_qe;
    logic [39:0]    w_qprod;

    assign w_qprod = {16'd0, r1_sum} * {24'd0, hslc_pkg::RECIP_255};

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_sum <= r1_sum;
            r2_qe  <= w_qprod[hslc_pkg::RECIP_SHIFT +: 17];
        end
    end

    // Stage 3: correct the estimate by one where the remainder reaches 255
    hslc_pkg::t_q16 r3_lum;
    logic [24:0]    w_qx255, w_rem;

    always_comb begin
        w_qx255 = ({8'd0, r2_qe} << 8) - {8'd0, r2_qe};
        w_rem   = {1'b0, r2_sum} - w_qx255;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_lum <= (w_rem >= 25'd255) ? r2_qe + 17'd1 : r2_qe;
        end
    end

    // Stage 4: lightness scale product
    logic [33:0]    r4_prod;
    hslc_pkg::t_q16 r4_off;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_prod <= {17'd0, r3_lum} * {17'd0, r_lf};
            r4_off  <= r_loff;
        end
    end

    // Stage 5: adjusted luminance
    hslc_pkg::t_q16 r5_lum;
    logic [17:0]    w_lum5;

    assign w_lum5 = {1'b0, r4_prod[32:16]} + {1'b0, r4_off};

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_lum <= w_lum5[16:0];
        end
    end

    // Stage 6: m2 product, lum*(1+s) on the dark half, lum*s on the bright half
    logic [34:0]    r6_prod;
    hslc_pkg::t_q16 r6_lum;
    logic           r6_dark;
    logic           w_dark;
    logic [17:0]    w_k;

    always_comb begin
        w_dark = (r5_lum <= hslc_pkg::HALF_Q16);
        w_k    = {1'b0, r_sat} + (w_dark ? {1'b0, hslc_pkg::ONE_Q16} : 18'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_prod <= {18'd0, r5_lum} * {17'd0, w_k};
            r6_lum  <= r5_lum;
            r6_dark <= w_dark;
        end
    end

    // Stage 7: m1 and the span m2 - m1 (zero saturation gives m1 = m2 = lum)
    hslc_pkg::t_q16 r7_m1, r7_span;
    logic [18:0]    w_m2, w_m1;

    always_comb begin
        if (r6_dark) begin
            w_m2 = {2'b00, r6_prod[32:16]};
        end else begin
            w_m2 = {2'b00, r6_lum} + {2'b00, r_sat} - {2'b00, r6_prod[32:16]};
        end
        w_m1 = ({2'b00, r6_lum} << 1) - w_m2;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r7_m1   <= w_m1[16:0];
            r7_span <= 17'(w_m2 - w_m1);
        end
    end

    // Stage 8: ramp products, one per channel
    logic [33:0]    r8_pr, r8_pg, r8_pb;
    hslc_pkg::t_q16 r8_m1;

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r8_pr <= {17'd0, r7_span} * {17'd0, r_w_red};
            r8_pg <= {17'd0, r7_span} * {17'd0, r_w_grn};
            r8_pb <= {17'd0, r7_span} * {17'd0, r_w_blu};
            r8_m1 <= r7_m1;
        end
    end

    // Stage 9: channel values, held to 1.0
    hslc_pkg::t_q16 r9_cr, r9_cg, r9_cb;
    logic [17:0]    w_cr, w_cg, w_cb;

    always_comb begin
        w_cr = {1'b0, r8_m1} + {1'b0, r8_pr[32:16]};
        w_cg = {1'b0, r8_m1} + {1'b0, r8_pg[32:16]};
        w_cb = {1'b0, r8_m1} + {1'b0, r8_pb[32:16]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            r9_cr <= (w_cr > {1'b0, hslc_pkg::ONE_Q16}) ? hslc_pkg::ONE_Q16 : w_cr[16:0];
            r9_cg <= (w_cg > {1'b0, hslc_pkg::ONE_Q16}) ? hslc_pkg::ONE_Q16 : w_cg[16:0];
            r9_cb <= (w_cb > {1'b0, hslc_pkg::ONE_Q16}) ? hslc_pkg::ONE_Q16 : w_cb[16:0];
        end
    end

    // Stage 10: bytes, floor(c * 255 / 65536) as shift and subtract
    logic [24:0] w_br, w_bg, w_bb;
    logic [31:0] r10_data;

    always_comb begin
        w_br = ({8'd0, r9_cr} << 8) - {8'd0, r9_cr};
        w_bg = ({8'd0, r9_cg} << 8) - {8'd0, r9_cg};
        w_bb = ({8'd0, r9_cb} << 8) - {8'd0, r9_cb};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[10]) begin
            r10_data <= {r_alpha[9], w_bb[23:16], w_bg[23:16], w_br[23:16]};
        end
    end

    assign m_tdata = r10_data;

    // r_alpha's last tap is unused by the data path; keep it visible for debug alignment
    logic w_alpha_match;
    assign w_alpha_match = (r_alpha[NSTG-1] == r10_data[31:24]);

`ifndef SYNTHESIS
    // Registers never leave 0..1.0
    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hue <= hslc_pkg::ONE_Q16) && (r_sat <= hslc_pkg::ONE_Q16)
        && (r_light <= hslc_pkg::ONE_Q16))
        else $error("configuration register above 1.0");

    // A hue write lands clamped on the next edge
    a_hue_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_addr == hslc_pkg::CFG_HUE))
        |=> (r_hue == hslc_pkg::clamp_reg($past(i_cfg_data))))
        else $error("hue register write mismatch");

    // A full pipeline stalled at the output takes no new pixel
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    // m2 = m1 + span stays within 1.0
    a_m2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (({1'b0, r7_m1} + {1'b0, r7_span}) <= {1'b0, hslc_pkg::ONE_Q16}))
        else $error("m2 out of range");

    // Alpha tap and output word agree whenever the output holds a pixel
    a_alpha_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> w_alpha_match)
        else $error("alpha lost alignment");
`endif

endmodule
